>>> hw/rtl/rei_pkg.sv
// Package: shared types and constants of the range extrapolation index.
package rei_pkg;

  localparam int DefNumCovariates = 16;
  localparam int ColW  = 4;
  localparam int QW    = 32;
  localparam int MagW  = 49;   // |d| << 16 fits in 33+16 bits
  localparam int RngW  = 33;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_REF    = 2'd1,
    ACT_TARGET = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Classified work passed from front to back.
  typedef struct packed {
    logic              has_term;   // nonzero difference, divide needed
    logic              degen;      // empty or zero range
    logic              last;       // close the row after this request
    logic [ColW-1:0]   col;
    logic [MagW-1:0]   mag;
    logic [RngW-1:0]   range;
  } work_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ACC
  } back_state_t;

endpackage

>>> hw/rtl/rei_front.sv
// Front end: keeps reference ranges and classifies target requests.
module rei_front #(
  parameter int NUM_COVARIATES = rei_pkg::DefNumCovariates
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [3:0]           column,
  input  logic signed [31:0]   value,
  input  logic                 row_end,
  output logic                 wq_valid,
  input  logic                 wq_ready,
  output rei_pkg::work_t       wq_data
);
  import rei_pkg::*;

  localparam int IdxW = (NUM_COVARIATES > 1) ? $clog2(NUM_COVARIATES) : 1;

  logic signed [QW-1:0] ref_min [NUM_COVARIATES];
  logic signed [QW-1:0] ref_max [NUM_COVARIATES];

  // Stage register holding one classified request
  logic  st_valid;
  work_t st;

  logic        col_ok;
  logic [IdxW-1:0] idx;
  logic signed [QW-1:0] lo, hi;
  logic signed [QW:0] dlo, dhi, d;
  logic        take;
  work_t       w;

  assign idx    = IdxW'(column);
  assign col_ok = 32'(column) < NUM_COVARIATES;
  assign lo     = ref_min[idx];
  assign hi     = ref_max[idx];
  assign in_ready = !st_valid || wq_ready;
  assign take   = in_valid && in_ready;

  // Term classification
  always_comb begin
    dlo = 33'(signed'(value)) - 33'(signed'(lo));
    dhi = 33'(signed'(hi)) - 33'(signed'(value));
    d   = '0;
    if (dlo < d) d = dlo;
    if (dhi < d) d = dhi;
    w          = '0;
    w.col      = column;
    w.last     = row_end;
    w.range    = RngW'(33'(signed'(hi)) - 33'(signed'(lo)));
    w.mag      = {16'(0), RngW'(-d)} << 16;
    if (col_ok) begin
      if (lo >= hi) w.degen = 1'b1;
      else if (d != '0) w.has_term = 1'b1;
    end
  end

  // Reference range update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COVARIATES; i++) begin
        ref_min[i] <= {1'b0, {(QW-1){1'b1}}};
        ref_max[i] <= {1'b1, {(QW-1){1'b0}}};
      end
    end else if (take) begin
      if (action_t'(action) == ACT_CLEAR) begin
        for (int i = 0; i < NUM_COVARIATES; i++) begin
          ref_min[i] <= {1'b0, {(QW-1){1'b1}}};
          ref_max[i] <= {1'b1, {(QW-1){1'b0}}};
        end
      end else if (action_t'(action) == ACT_REF && col_ok) begin
        if (value < lo) ref_min[idx] <= value;
        if (value > hi) ref_max[idx] <= value;
      end
    end
  end

  // Hand-off register towards the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= take && action_t'(action) == ACT_TARGET;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ready) st <= w;
  end

  assign wq_valid = st_valid;
  assign wq_data  = st;
endmodule

>>> hw/rtl/rei_queue.sv
// Short queue between front and back ends.
module rei_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rei_pkg::work_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output rei_pkg::work_t  rd_data
);
  import rei_pkg::*;

  work_t       mem [2];
  logic        wp, rp;
  logic [1:0]  cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  // Write side
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("queue count out of range");
  a_empty_steady: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 && !wr_valid) |=> cnt == 2'd0) else $error("queue filled itself");
endmodule

>>> hw/rtl/rei_back.sv
// Back end: serial divider, row accumulator and result register.
module rei_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                wq_valid,
  output logic                wq_ready,
  input  rei_pkg::work_t      wq_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  nt1,
  output logic [4:0]          most_influential,
  output logic                degenerate,
  output logic                saturated
);
  import rei_pkg::*;

  localparam int CntW = $clog2(MagW + 1);

  back_state_t state, state_next;
  work_t       cur;
  logic [MagW-1:0] quo;
  logic [RngW:0]   rem;
  logic [CntW-1:0] cnt;

  logic signed [QW-1:0] row_sum, best_term;
  logic [4:0]  best_col;
  logic        row_degenerate, row_saturated;

  logic [RngW:0] trial;
  logic          sat_q;
  logic signed [QW:0] term, sum_w;
  logic          take;

  assign take  = wq_valid && wq_ready;
  assign trial = {rem[RngW-1:0], quo[MagW-1]} - {1'b0, cur.range};
  assign sat_q = quo > MagW'(33'h8000_0000);
  assign term  = sat_q ? -33'sh8000_0000 : -signed'({1'b0, quo[QW-1:0]});
  assign sum_w = 33'(row_sum) + term;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (take && wq_data.has_term) state_next = BK_DIV;
      BK_DIV:  if (cnt == CntW'(MagW - 1)) state_next = BK_ACC;
      BK_ACC:  if (!cur.last || !out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    wq_ready = 1'b0;
    unique case (state)
      BK_IDLE: wq_ready = !(wq_data.last && out_valid && !out_ready);
      default: wq_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && take) begin
      cur <= wq_data;
      quo <= wq_data.mag;
      rem <= '0;
      cnt <= '0;
    end else if (state == BK_DIV) begin
      cnt <= cnt + 1'b1;
      if (!trial[RngW]) begin
        rem <= trial;
        quo <= {quo[MagW-2:0], 1'b1};
      end else begin
        rem <= {rem[RngW-1:0], quo[MagW-1]};
        quo <= {quo[MagW-2:0], 1'b0};
      end
    end
  end

  // Row accumulation and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum <= '0; best_term <= '0; best_col <= '0;
      row_degenerate <= 1'b0; row_saturated <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      logic signed [QW-1:0] s;
      logic [4:0]  bc;
      logic signed [QW-1:0] bt;
      logic dg, sa, fin;
      s = row_sum; bc = best_col; bt = best_term;
      dg = row_degenerate; sa = row_saturated; fin = 1'b0;
      if (state == BK_IDLE && take && !wq_data.has_term) begin
        dg  = dg | wq_data.degen;
        fin = wq_data.last;
      end else if (state == BK_ACC && state_next == BK_IDLE) begin
        sa = sa | sat_q;
        if (term != '0) begin
          if (sum_w < -33'sh8000_0000) begin
            s = {1'b1, {(QW-1){1'b0}}}; sa = 1'b1;
          end else s = QW'(sum_w);
          // ties go to the lowest column
          if (bc == '0 || term < 33'(bt) ||
              (term == 33'(bt) && 5'(cur.col) + 5'd1 < bc)) begin
            bt = QW'(term); bc = 5'(cur.col) + 5'd1;
          end
        end
        fin = cur.last;
      end
      if (fin) begin
        nt1 <= s; most_influential <= bc; degenerate <= dg; saturated <= sa;
        out_valid <= 1'b1;
        row_sum <= '0; best_term <= '0; best_col <= '0;
        row_degenerate <= 1'b0; row_saturated <= 1'b0;
      end else begin
        if (out_valid && out_ready) out_valid <= 1'b0;
        row_sum <= s; best_term <= bt; best_col <= bc;
        row_degenerate <= dg; row_saturated <= sa;
      end
    end
  end

  a_sum_nonpos: assert property (@(posedge clk) disable iff (rst)
    row_sum <= 0) else $error("row sum positive");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIV && cnt == CntW'(MagW - 1) |=> state == BK_ACC)
    else $error("divider length");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> !wq_ready) else $error("took work while busy");
endmodule

>>> hw/rtl/range_extrapolation_index.sv
// Top level of the univariate range extrapolation index (NT1) block.
// Input channel (in_valid/in_ready) carries action, column, value, row_end.
// Action 0 clears all reference ranges, 1 widens a column's range, 2 adds a
// target term to the running row; a target with row_end closes the row and
// one result (nt1, most_influential, degenerate, saturated) appears on the
// output channel (out_valid/out_ready).
// The front end takes one request a cycle, while its hand-off register is free
// or the two-entry queue has room, into that register and then the queue.
// The back end finishes a target whose term is zero or degenerate straight
// from idle; one with a nonzero difference goes to a restoring divider that
// yields one of 49 quotient bits a cycle, then to an accumulate state.
// Reference and clear requests never reach the back end.
// The result sits in a register; while the receiver stalls, earlier terms
// keep running, and only the next row-closing term waits.
// Reset empties all ranges, the queue and the row, and drops out_valid.
module range_extrapolation_index #(
  parameter int NUM_COVARIATES = rei_pkg::DefNumCovariates
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [3:0]          column,
  input  logic signed [31:0]  value,
  input  logic                row_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  nt1,
  output logic [4:0]          most_influential,
  output logic                degenerate,
  output logic                saturated
);
  import rei_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  work_t f_data, b_data;

  rei_front #(.NUM_COVARIATES(NUM_COVARIATES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .action, .column, .value, .row_end,
    .wq_valid(f_valid), .wq_ready(f_ready), .wq_data(f_data)
  );

  rei_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  rei_back u_back (
    .clk, .rst, .wq_valid(b_valid), .wq_ready(b_ready), .wq_data(b_data),
    .out_valid, .out_ready, .nt1, .most_influential, .degenerate, .saturated
  );
endmodule
